/* hdl/spq_pkg.sv */
package spq_pkg;

  localparam int unsigned Depth = 8;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  localparam int unsigned ValW   = 32;
  localparam int unsigned PriW   = 8;
  localparam int unsigned TotalW = 4;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_STATUS = 2'd2,
    OP_SPARE  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_FULL       = 2'd1,
    ST_EMPTY      = 2'd2,
    ST_RESERVED   = 2'd3
  } status_e;

  // One slot of the sorted row.
  typedef struct packed {
    logic            valid;
    logic [PriW-1:0] pri;
    logic [ValW-1:0] val;
  } entry_t;

  // Broadcast to every cell for one transaction.
  typedef struct packed {
    logic            insert;
    logic            remove;
    logic [PriW-1:0] pri;
    logic [ValW-1:0] val;
  } cell_ctrl_t;

endpackage

/* hdl/spq_cell.sv */
module spq_cell
  import spq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  logic       left_keep_i,
  input  entry_t     left_entry_i,
  input  entry_t     right_entry_i,
  output logic       keep_o,
  output entry_t     entry_o
);

  logic            valid_q, valid_d;
  logic [PriW-1:0] pri_q, pri_d;
  logic [ValW-1:0] val_q, val_d;

  // Entry stays put on insert when it ranks at or above the new one.
  assign keep_o  = valid_q && (pri_q >= ctrl_i.pri);
  assign entry_o = '{valid: valid_q, pri: pri_q, val: val_q};

  always_comb begin
    valid_d = valid_q;
    pri_d   = pri_q;
    val_d   = val_q;
    if (ctrl_i.insert && !keep_o) begin
      if (left_keep_i) begin
        valid_d = 1'b1;
        pri_d   = ctrl_i.pri;
        val_d   = ctrl_i.val;
      end else begin
        valid_d = left_entry_i.valid;
        pri_d   = left_entry_i.pri;
        val_d   = left_entry_i.val;
      end
    end else if (ctrl_i.remove) begin
      valid_d = right_entry_i.valid;
      pri_d   = right_entry_i.pri;
      val_d   = right_entry_i.val;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pri_q <= pri_d;
    val_q <= val_d;
  end

endmodule

/* hdl/sorted_priority_queue.sv */
// Sorted priority queue of Depth (priority, value) entries held in a row of cells, highest
// priority in cell 0. On each transaction every cell compares its priority with the
// incoming one in parallel and either holds, loads the new entry, or takes its neighbor's
// entry, so an insert or remove shifts the whole row at once. Equal
// priorities leave in arrival order. A new transaction is taken every cycle as long as the
// result register is empty or being drained in the same cycle; head, tail, count and the
// empty/full flags in a result reflect the queue after that transaction.
module sorted_priority_queue
  import spq_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [1:0]             opcode_i,
  input  logic signed [ValW-1:0] item_value_i,
  input  logic [PriW-1:0]        item_priority_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic signed [ValW-1:0] removed_value_o,
  output logic [PriW-1:0]        removed_priority_o,
  output logic signed [ValW-1:0] head_value_o,
  output logic signed [ValW-1:0] tail_value_o,
  output logic [TotalW-1:0]      entry_total_o,
  output logic                   is_empty_o,
  output logic                   is_full_o
);

  entry_t     entries [Depth];
  logic       keeps   [Depth];
  logic       left_keep   [Depth];
  entry_t     left_entry  [Depth];
  entry_t     right_entry [Depth];
  cell_ctrl_t ctrl;

  logic             accept;
  logic             full, empty;
  logic [Depth:0]   valid_ext;
  logic [CntW-1:0]  count;
  logic [ValW-1:0]  tail;
  status_e          status_d;

  logic             out_valid_q;
  status_e          status_q;
  logic [PriW-1:0]  rem_pri_q;
  logic [ValW-1:0]  rem_val_q;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  assign full  = entries[Depth-1].valid;
  assign empty = !entries[0].valid;

  always_comb begin
    ctrl.insert = accept && (opcode_e'(opcode_i) == OP_INSERT) && !full;
    ctrl.remove = accept && (opcode_e'(opcode_i) == OP_REMOVE) && !empty;
    ctrl.pri    = item_priority_i;
    ctrl.val    = item_value_i;
  end

  always_comb begin
    case (opcode_e'(opcode_i))
      OP_INSERT: status_d = full  ? ST_FULL  : ST_DONE;
      OP_REMOVE: status_d = empty ? ST_EMPTY : ST_DONE;
      default:   status_d = ST_DONE;
    endcase
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_keep[i]  = 1'b1;
      assign left_entry[i] = '0;
    end else begin : g_mid
      assign left_keep[i]  = keeps[i-1];
      assign left_entry[i] = entries[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_entry[i] = '0;
    end else begin : g_inner
      assign right_entry[i] = entries[i+1];
    end

    spq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .left_keep_i   (left_keep[i]),
      .left_entry_i  (left_entry[i]),
      .right_entry_i (right_entry[i]),
      .keep_o        (keeps[i]),
      .entry_o       (entries[i])
    );
  end

  // Occupancy is a thermometer over the cells; the tail is the last valid one.
  always_comb begin
    valid_ext = '0;
    for (int i = 0; i < Depth; i++) begin
      valid_ext[i] = entries[i].valid;
    end
  end

  always_comb begin
    count = '0;
    tail  = '0;
    for (int i = 0; i < Depth; i++) begin
      count = count + CntW'(valid_ext[i]);
      if (valid_ext[i] && !valid_ext[i+1]) begin
        tail = tail | entries[i].val;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q  <= status_d;
      rem_pri_q <= ctrl.remove ? entries[0].pri : '0;
      rem_val_q <= ctrl.remove ? entries[0].val : '0;
    end
  end

  logic [CntW+TotalW-1:0] count_wide;
  assign count_wide = {{TotalW{1'b0}}, count};

  assign out_valid_o        = out_valid_q;
  assign status_o           = status_q;
  assign removed_value_o    = rem_val_q;
  assign removed_priority_o = rem_pri_q;
  assign head_value_o       = empty ? '0 : entries[0].val;
  assign tail_value_o       = tail;
  assign entry_total_o      = count_wide[TotalW-1:0];
  assign is_empty_o         = empty;
  assign is_full_o          = full;

endmodule

/* hdl/spq_checker.sv */
module spq_checker
  import spq_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             status_o,
  input logic signed [ValW-1:0] removed_value_o,
  input logic [PriW-1:0]        removed_priority_o,
  input logic signed [ValW-1:0] head_value_o,
  input logic [TotalW-1:0]      entry_total_o,
  input logic                   is_empty_o,
  input logic                   is_full_o
);

  // Result transaction holds until taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(removed_value_o))
    else $error("result dropped or changed while stalled");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(is_empty_o && is_full_o))
    else $error("queue reported both empty and full");

  a_empty_view: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && is_empty_o |-> entry_total_o == '0 && head_value_o == '0)
    else $error("empty queue shows entries");

  a_full_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_FULL |-> is_full_o && removed_priority_o == '0)
    else $error("insert refused without a full queue");

  a_empty_refused: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o == ST_EMPTY |-> is_empty_o && removed_value_o == '0)
    else $error("remove refused without an empty queue");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .in_valid_i         (in_valid_i),
  .in_ready_o         (in_ready_o),
  .out_valid_o        (out_valid_o),
  .out_ready_i        (out_ready_i),
  .status_o           (status_o),
  .removed_value_o    (removed_value_o),
  .removed_priority_o (removed_priority_o),
  .head_value_o       (head_value_o),
  .entry_total_o      (entry_total_o),
  .is_empty_o         (is_empty_o),
  .is_full_o          (is_full_o)
);
